// ===== hw/rtl/jpr_pkg.sv =====
// Shared types, constants and helpers for the Jacobi recurrence evaluator.
`default_nettype none

package jpr_pkg;

  // Field and datapath widths
  localparam int FIELD_W   = 4;
  localparam int POINT_W   = 26;
  localparam int DATA_W    = 64;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 24;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = HALF_W + DATA_W;

  // Coefficient ROM geometry: one row per (alpha, order) pair
  localparam int ROM_DIM   = 16;
  localparam int ROM_ROWS  = ROM_DIM * ROM_DIM;
  localparam int ROM_IDX_W = 2 * FIELD_W;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Three recurrence coefficients for one (alpha, order) pair
  typedef struct packed {
    coef_t c10;
    coef_t c11;
    coef_t c2;
  } coef_row_t;

  // Request to the shared multiply-round-saturate unit
  typedef struct packed {
    logic              start;
    logic [HALF_W-1:0] a_mag;
    logic              a_neg;
    data_t             b;
  } mul_req_t;

  // Response from the shared unit
  typedef struct packed {
    logic  done;
    data_t value;
    logic  ovf;
  } mul_rsp_t;

  typedef struct packed {
    data_t value;
    logic  ovf;
  } sat_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_MSTART,
    ST_MWAIT,
    ST_OUT
  } state_t;

  // Multiplications of one recurrence step, in issue order
  typedef enum logic [1:0] {
    OP_C10,
    OP_Z,
    OP_C11,
    OP_C2
  } mul_op_t;

  // Signed add that clamps to the 64-bit range
  function automatic sat_res_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    sat_res_t               r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      r.ovf   = 1'b1;
      r.value = s[DATA_W] ? $signed(DATA_MIN) : $signed(DATA_MAX);
    end else begin
      r.ovf   = 1'b0;
      r.value = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jpr_ifs.sv =====
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface jpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [jpr_pkg::FIELD_W-1:0]         order;
  logic [jpr_pkg::FIELD_W-1:0]         alpha_index;
  logic signed [jpr_pkg::POINT_W-1:0]  point;

  modport source (output valid, order, alpha_index, point, input ready);
  modport sink   (input valid, order, alpha_index, point, output ready);
endinterface

interface jpr_out_if;
  logic                 valid;
  logic                 ready;
  jpr_pkg::data_t       value;
  logic                 overflow;

  modport source (output valid, value, overflow, input ready);
  modport sink   (input valid, value, overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jpr_coef_rom.sv =====
// Recurrence coefficient ROM, Q8.24, built at elaboration, registered read.
`default_nettype none

module jpr_coef_rom (
  input  logic                           clk,
  input  logic [jpr_pkg::FIELD_W-1:0]    alpha,
  input  logic [jpr_pkg::FIELD_W-1:0]    order,
  output jpr_pkg::coef_row_t             row
);

  jpr_pkg::coef_row_t rom_w [jpr_pkg::ROM_ROWS];
  jpr_pkg::coef_row_t row_r;

  // Build each row from the exact rational value, rounded half away from zero
  for (genvar ga = 0; ga < jpr_pkg::ROM_DIM; ga++) begin : g_alpha
    for (genvar gk = 0; gk < jpr_pkg::ROM_DIM; gk++) begin : g_ord
      // Orders below two never index the ROM; fill them with order-two values
      localparam longint Kc   = (gk < 2) ? 2 : gk;
      localparam longint Al   = ga;
      localparam longint Cc   = 2 * Kc + Al + 1;
      localparam longint Den  = 2 * Kc * (Kc + Al + 1) * (Cc - 2);
      localparam longint Num0 = (Cc - 1) * Cc * (Cc - 2);
      localparam longint Num1 = (Cc - 1) * (Al - 1) * (Al + 1);
      localparam longint Num2 = -2 * (Kc + Al - 1) * Kc * Cc;
      localparam longint Mag0 = (Num0 < 0) ? -Num0 : Num0;
      localparam longint Mag1 = (Num1 < 0) ? -Num1 : Num1;
      localparam longint Mag2 = (Num2 < 0) ? -Num2 : Num2;
      localparam longint Q0   = ((Mag0 <<< jpr_pkg::COEF_FRAC) + Den / 2) / Den;
      localparam longint Q1   = ((Mag1 <<< jpr_pkg::COEF_FRAC) + Den / 2) / Den;
      localparam longint Q2   = ((Mag2 <<< jpr_pkg::COEF_FRAC) + Den / 2) / Den;
      localparam longint S0   = (Num0 < 0) ?
                                ((Q0 > 64'sh8000_0000) ? -64'sh8000_0000 : -Q0) :
                                ((Q0 > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : Q0);
      localparam longint S1   = (Num1 < 0) ?
                                ((Q1 > 64'sh8000_0000) ? -64'sh8000_0000 : -Q1) :
                                ((Q1 > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : Q1);
      localparam longint S2   = (Num2 < 0) ?
                                ((Q2 > 64'sh8000_0000) ? -64'sh8000_0000 : -Q2) :
                                ((Q2 > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : Q2);

      assign rom_w[ga * jpr_pkg::ROM_DIM + gk] =
        {S0[jpr_pkg::COEF_W-1:0], S1[jpr_pkg::COEF_W-1:0], S2[jpr_pkg::COEF_W-1:0]};
    end
  end

  // Register the selected row
  always_ff @(posedge clk) begin
    row_r <= rom_w[{alpha, order}];
  end

  assign row = row_r;

endmodule

`default_nettype wire

// ===== hw/rtl/jpr_mul.sv =====
// Shared multiply unit: 32x64 magnitude product in two halves, round, saturate.
`default_nettype none

module jpr_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  jpr_pkg::mul_req_t   req,
  output jpr_pkg::mul_rsp_t   rsp
);

  localparam int HugeLo = jpr_pkg::DATA_W + jpr_pkg::COEF_FRAC;

  logic [jpr_pkg::HALF_W-1:0]   a_r;
  logic [jpr_pkg::DATA_W-1:0]   bm_r;
  logic                         neg_r;
  logic [2:0]                   ph_r;
  logic [jpr_pkg::DATA_W-1:0]   p0_r;
  logic [jpr_pkg::DATA_W-1:0]   p1_r;
  logic                         done_r;
  logic [jpr_pkg::DATA_W-1:0]   val_r;
  logic                         ovf_r;

  logic [jpr_pkg::HALF_W-1:0]   b_half;
  logic [jpr_pkg::DATA_W-1:0]   prod;
  logic [jpr_pkg::PROD_W-1:0]   rnd;
  logic [jpr_pkg::DATA_W-1:0]   mag;
  logic [jpr_pkg::DATA_W-1:0]   lim;
  logic [jpr_pkg::DATA_W-1:0]   mag_sat;
  logic                         huge;
  logic                         ovf_c;

  // One 32x32 multiplier, fed the low half first, then the high half
  always_comb begin
    b_half = ph_r[0] ? bm_r[jpr_pkg::HALF_W-1:0] : bm_r[jpr_pkg::DATA_W-1:jpr_pkg::HALF_W];
    prod   = jpr_pkg::DATA_W'(a_r) * jpr_pkg::DATA_W'(b_half);
  end

  // Round half away from zero on the magnitude, then clamp to the signed range
  always_comb begin
    rnd     = {p1_r, p0_r[jpr_pkg::HALF_W-1:0]}
              + (jpr_pkg::PROD_W'(1) << (jpr_pkg::COEF_FRAC - 1));
    huge    = |rnd[jpr_pkg::PROD_W-1:HugeLo];
    mag     = rnd[HugeLo-1:jpr_pkg::COEF_FRAC];
    lim     = neg_r ? jpr_pkg::DATA_MIN : jpr_pkg::DATA_MAX;
    ovf_c   = huge || (mag > lim);
    mag_sat = ovf_c ? lim : mag;
  end

  // Advance the phase chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[1:0], req.start};
      done_r <= ph_r[2];
    end
  end

  // Capture operands, accumulate partial products, hold the result
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a_mag;
      bm_r  <= req.b[jpr_pkg::DATA_W-1] ? jpr_pkg::DATA_W'(-req.b) : jpr_pkg::DATA_W'(req.b);
      neg_r <= req.a_neg ^ req.b[jpr_pkg::DATA_W-1];
    end
    if (ph_r[0]) begin
      p0_r <= prod;
    end
    if (ph_r[1]) begin
      p1_r <= prod + {{jpr_pkg::HALF_W{1'b0}}, p0_r[jpr_pkg::DATA_W-1:jpr_pkg::HALF_W]};
    end
    if (ph_r[2]) begin
      val_r <= neg_r ? (~mag_sat + 1'b1) : mag_sat;
      ovf_r <= ovf_c;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = $signed(val_r);
  assign rsp.ovf   = ovf_r;

  // A new operation only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (ph_r == 3'b000) && !done_r)
    else $error("multiply started while busy");

  // At most one phase active
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ph_r))
    else $error("multiply phases overlap");

  // Done is raised in the cycle after the last phase
  a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(ph_r[2]))
    else $error("multiply done without final phase");

endmodule

`default_nettype wire

// ===== hw/rtl/jacobi_polynomial_recurrence_eval.sv =====
// An item of order 0 or 1 goes from init straight to the result load; higher orders take
// one recurrence step for each order from 2 to n. Each step is one ROM fetch plus four
// multiplications on the single shared 32x32 multiplier (two partial products, round).
// One item is in flight; the next is taken in the idle state after the previous result
// loads, and a held output stalls the load.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid.
`default_nettype none

module jacobi_polynomial_recurrence_eval #(
  parameter int MAX_ORDER   = 15,
  parameter int ALPHA_LIMIT = 15,
  parameter int FRAC_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  jpr_in_if.sink            in_ch,
  jpr_out_if.source         out_ch
);

  localparam int OrdCapI = (MAX_ORDER > 15) ? 15 : MAX_ORDER;
  localparam int AlCapI  = (ALPHA_LIMIT > 15) ? 15 : ALPHA_LIMIT;
  localparam logic [jpr_pkg::FIELD_W-1:0] ORD_CAP = jpr_pkg::FIELD_W'(OrdCapI);
  localparam logic [jpr_pkg::FIELD_W-1:0] AL_CAP  = jpr_pkg::FIELD_W'(AlCapI);
  // Order-one term carries COEF_FRAC+1 fraction bits before rescaling
  localparam int Up   = FRAC_BITS - (jpr_pkg::COEF_FRAC + 1);
  localparam int UpL  = (Up >= 0) ? Up : 0;
  localparam int Dn   = (Up < 0) ? -Up : 1;
  localparam logic [jpr_pkg::DATA_W-1:0] ONE = jpr_pkg::DATA_W'(1) << FRAC_BITS;

  jpr_pkg::state_t                     state_r, state_nxt;
  jpr_pkg::mul_op_t                    op_r;
  logic [jpr_pkg::FIELD_W-1:0]         n_r;
  logic [jpr_pkg::FIELD_W-1:0]         k_r;
  logic [jpr_pkg::FIELD_W-1:0]         al_r;
  logic signed [jpr_pkg::POINT_W-1:0]  z_r;
  jpr_pkg::data_t                      pm1_r;
  jpr_pkg::data_t                      pm2_r;
  jpr_pkg::data_t                      acc_r;
  logic                                ov_r;
  logic                                out_valid_r;
  jpr_pkg::data_t                      out_value_r;
  logic                                out_ovf_r;

  logic                                in_ready;
  logic                                out_load;
  logic                                mul_start;
  jpr_pkg::mul_req_t                   req;
  jpr_pkg::mul_rsp_t                   rsp;
  jpr_pkg::coef_row_t                  row;
  jpr_pkg::coef_t                      coef_sel;
  jpr_pkg::sat_res_t                   sum;

  logic [4:0]                          al3;
  logic signed [26:0]                  zd;
  logic signed [32:0]                  tp;
  logic [32:0]                         tmag;
  logic [32:0]                         trnd;
  jpr_pkg::data_t                      t64;
  logic [jpr_pkg::DATA_W-1:0]          al1;
  jpr_pkg::data_t                      pm1_init;

  jpr_coef_rom u_rom (
    .clk   (clk),
    .alpha (al_r),
    .order (k_r),
    .row   (row)
  );

  jpr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jpr_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = jpr_pkg::ST_INIT;
      end
      jpr_pkg::ST_INIT: begin
        state_nxt = (n_r <= 4'd1) ? jpr_pkg::ST_OUT : jpr_pkg::ST_FETCH;
      end
      jpr_pkg::ST_FETCH: begin
        state_nxt = jpr_pkg::ST_MSTART;
      end
      jpr_pkg::ST_MSTART: begin
        state_nxt = jpr_pkg::ST_MWAIT;
      end
      jpr_pkg::ST_MWAIT: begin
        if (rsp.done) begin
          if (op_r != jpr_pkg::OP_C2) begin
            state_nxt = jpr_pkg::ST_MSTART;
          end else if (k_r == n_r) begin
            state_nxt = jpr_pkg::ST_OUT;
          end else begin
            state_nxt = jpr_pkg::ST_FETCH;
          end
        end
      end
      jpr_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = jpr_pkg::ST_IDLE;
      end
      default: state_nxt = jpr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (state_r == jpr_pkg::ST_IDLE);
    out_load  = (state_r == jpr_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);
    mul_start = (state_r == jpr_pkg::ST_MSTART);
  end

  // Pick multiplier operands for the current operation
  always_comb begin
    req.start = mul_start;
    case (op_r)
      jpr_pkg::OP_C10: coef_sel = row.c10;
      jpr_pkg::OP_C11: coef_sel = row.c11;
      jpr_pkg::OP_C2:  coef_sel = row.c2;
      default:         coef_sel = row.c10;
    endcase
    if (op_r == jpr_pkg::OP_Z) begin
      req.a_neg = z_r[jpr_pkg::POINT_W-1];
      req.a_mag = z_r[jpr_pkg::POINT_W-1] ? jpr_pkg::HALF_W'(-z_r) : jpr_pkg::HALF_W'(z_r);
    end else begin
      req.a_neg = coef_sel[jpr_pkg::COEF_W-1];
      req.a_mag = coef_sel[jpr_pkg::COEF_W-1] ? jpr_pkg::HALF_W'(-coef_sel)
                                              : jpr_pkg::HALF_W'(coef_sel);
    end
    case (op_r)
      jpr_pkg::OP_C10: req.b = pm1_r;
      jpr_pkg::OP_Z:   req.b = acc_r;
      jpr_pkg::OP_C11: req.b = pm1_r;
      jpr_pkg::OP_C2:  req.b = pm2_r;
      default:         req.b = pm1_r;
    endcase
  end

  // Accumulate products of one step
  assign sum = jpr_pkg::sat_add(acc_r, rsp.value);

  // Order-one value: (alpha+1) + (alpha+3)(z-1)/2, rescaled to FRAC_BITS
  always_comb begin
    al3  = {1'b0, al_r} + 5'd3;
    zd   = 27'(z_r) - 27'sd16777216;
    tp   = 33'($signed({1'b0, al3})) * 33'(zd);
    tmag = tp[32] ? 33'(-tp) : 33'(tp);
    trnd = (tmag + (33'(1) << (Dn - 1))) >> Dn;
    if (Up >= 0) begin
      t64 = jpr_pkg::DATA_W'(tp) <<< UpL;
    end else begin
      t64 = tp[32] ? -$signed(jpr_pkg::DATA_W'(trnd)) : $signed(jpr_pkg::DATA_W'(trnd));
    end
    al1      = jpr_pkg::DATA_W'(al_r) + 64'd1;
    pm1_init = $signed(al1 << FRAC_BITS) + t64;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jpr_pkg::ST_IDLE;
      op_r        <= jpr_pkg::OP_C10;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == jpr_pkg::ST_INIT) begin
        op_r <= jpr_pkg::OP_C10;
        ov_r <= 1'b0;
      end else if ((state_r == jpr_pkg::ST_MWAIT) && rsp.done) begin
        case (op_r)
          jpr_pkg::OP_C10: op_r <= jpr_pkg::OP_Z;
          jpr_pkg::OP_Z:   op_r <= jpr_pkg::OP_C11;
          jpr_pkg::OP_C11: op_r <= jpr_pkg::OP_C2;
          jpr_pkg::OP_C2:  op_r <= jpr_pkg::OP_C10;
          default:         op_r <= jpr_pkg::OP_C10;
        endcase
        if ((op_r == jpr_pkg::OP_C11) || (op_r == jpr_pkg::OP_C2)) begin
          ov_r <= ov_r | rsp.ovf | sum.ovf;
        end else begin
          ov_r <= ov_r | rsp.ovf;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and recurrence datapath
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      n_r  <= (in_ch.order > ORD_CAP) ? ORD_CAP : in_ch.order;
      al_r <= (in_ch.alpha_index > AL_CAP) ? AL_CAP : in_ch.alpha_index;
      z_r  <= in_ch.point;
    end
    if (state_r == jpr_pkg::ST_INIT) begin
      pm2_r <= $signed(ONE);
      pm1_r <= (n_r == 4'd0) ? $signed(ONE) : pm1_init;
      k_r   <= 4'd2;
    end else if ((state_r == jpr_pkg::ST_MWAIT) && rsp.done) begin
      case (op_r)
        jpr_pkg::OP_C10: acc_r <= rsp.value;
        jpr_pkg::OP_Z:   acc_r <= rsp.value;
        jpr_pkg::OP_C11: acc_r <= sum.value;
        jpr_pkg::OP_C2: begin
          pm1_r <= sum.value;
          pm2_r <= pm1_r;
          k_r   <= k_r + 4'd1;
        end
        default: acc_r <= rsp.value;
      endcase
    end
    if (out_load) begin
      out_value_r <= pm1_r;
      out_ovf_r   <= ov_r;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.overflow = out_ovf_r;

  // Multiply results only arrive while the sequencer waits for them
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == jpr_pkg::ST_MWAIT))
    else $error("multiply result outside wait state");

  // Recurrence steps stay within the requested order
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jpr_pkg::ST_MSTART) |-> (k_r >= 4'd2) && (k_r <= n_r))
    else $error("recurrence step out of range");

  // Orders zero and one never report overflow
  a_low_order_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && (n_r <= 4'd1) |-> !out_ovf_r)
    else $error("overflow flagged on order below two");

endmodule

`default_nettype wire
